// ===== rtl/drt_pkg.sv =====
// Shared types, widths and codes for the drift time table builder.
// No dependencies; every other file of the block refers to this package.
package drt_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int COUNT_BITS      = 24;
    localparam int FRAC_BITS       = 16;
    localparam int FRAC_W          = FRAC_BITS + 1;
    localparam int INDEX_W         = 12;
    localparam int TDC_W           = 16;
    localparam int MODE_W          = 2;
    localparam int STATUS_W        = 2;
    localparam int GATE_W          = 12;
    localparam int ENTRY_W         = 13;
    localparam int SUM_W           = COUNT_BITS + GATE_W;
    localparam int VAL_W           = (COUNT_BITS > FRAC_W) ? COUNT_BITS : FRAC_W;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 13;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BUILD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_GATE_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_SUM = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GATE_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_END    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd2;

    // 1.0 in Q1.FRAC_BITS
    localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic             present;
        logic [VAL_W-1:0] value;
    } t_word;

    typedef struct packed {
        logic [GATE_W-1:0]  gate_start;
        logic [GATE_W-1:0]  gate_end;
        logic [ENTRY_W-1:0] entry_count;
    } t_cfg;

    typedef struct packed {
        logic                kind;
        logic [STATUS_W-1:0] status;
        logic [FRAC_W-1:0]   fraction;
        logic                dvalid;
    } t_result;

    typedef struct packed {
        logic busy;
        logic table_ready;
    } t_seq_status;

endpackage

// ===== rtl/drt_in_if.sv =====
// Input item channel: valid/ready plus the item fields.
// Depends on drt_pkg for field widths.
interface drt_in_if;
    logic                           valid;
    logic                           ready;
    logic [drt_pkg::MODE_W-1:0]     mode;
    logic [drt_pkg::INDEX_W-1:0]    bin_index;
    logic [drt_pkg::COUNT_BITS-1:0] bin_count;
    logic [drt_pkg::TDC_W-1:0]      tdc_value;

    modport source (output valid, mode, bin_index, bin_count, tdc_value, input ready);
    modport sink   (input valid, mode, bin_index, bin_count, tdc_value, output ready);
endinterface

// ===== rtl/drt_out_if.sv =====
// Result channel: valid/ready plus the result fields.
// Depends on drt_pkg for field widths.
interface drt_out_if;
    logic                         valid;
    logic                         ready;
    logic                         result_kind;
    logic [drt_pkg::STATUS_W-1:0] build_status;
    logic [drt_pkg::FRAC_W-1:0]   distance_fraction;
    logic                         distance_valid;

    modport source (output valid, result_kind, build_status, distance_fraction,
                    distance_valid, input ready);
    modport sink   (input valid, result_kind, build_status, distance_fraction,
                    distance_valid, output ready);
endinterface

// ===== rtl/drt_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and data.
// Depends on drt_pkg for widths.
interface drt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [drt_pkg::CFG_IDX_W-1:0]  index;
    logic [drt_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/drt_time_table_builder.sv =====
// Top level of the drift time table builder: configuration registers and result register.
// Depends on drt_pkg, the three channel interfaces and drt_seq.
//
// Loads may arrive back to back while no result waits in the pending stage. A lookup
// makes a synchronous read of the table store and then forms the result, and the next
// item is not taken until it is done. A build walks the store through its read port and
// write port: it sums the gated bins and checks the total, then runs the per-entry
// divisions in the one-bit-a-cycle divider, then marks the entries outside the gate
// absent, up to the clamped entry count. Gate errors and an empty gate answer straight
// from the idle state. Every result then passes through the pending stage into the output
// register. A result register and a pending stage let the next item in while a result
// is still waiting on the output. The store needs no clearing after reset.
module drift_time_table_builder #(
    parameter int TABLE_DEPTH = drt_pkg::TABLE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    drt_in_if.sink     i_item,
    drt_out_if.source  o_result,
    drt_cfg_if.sink    i_cfg
);

    drt_pkg::t_cfg         r_cfg;
    logic                  r_out_valid;
    drt_pkg::t_result      r_out;
    drt_pkg::t_result      w_pend;
    logic                  w_pend_valid;
    logic                  w_pend_take;
    drt_pkg::t_seq_status  w_status;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                drt_pkg::CFG_GATE_START:  r_cfg.gate_start  <= i_cfg.data[drt_pkg::GATE_W-1:0];
                drt_pkg::CFG_GATE_END:    r_cfg.gate_end    <= i_cfg.data[drt_pkg::GATE_W-1:0];
                drt_pkg::CFG_ENTRY_COUNT: r_cfg.entry_count <= i_cfg.data[drt_pkg::ENTRY_W-1:0];
                default: ;
            endcase
        end
    end

    drt_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_cfg        (r_cfg),
        .i_pend_take  (w_pend_take),
        .o_pend       (w_pend),
        .o_pend_valid (w_pend_valid),
        .o_status     (w_status)
    );

    // pending result moves on when the output register is empty or being emptied
    assign w_pend_take = w_pend_valid && (!r_out_valid || o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pend_take) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_pend_take) begin
            r_out <= w_pend;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.result_kind       = r_out.kind;
    assign o_result.build_status      = r_out.status;
    assign o_result.distance_fraction = r_out.fraction;
    assign o_result.distance_valid    = r_out.dvalid;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.ready |-> !w_status.busy)
        else $error("item accepted while a build or lookup is in progress");

    a_load_clears_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready && i_item.mode == drt_pkg::MODE_LOAD)
        |=> !w_status.table_ready)
        else $error("table still marked ready after a load");

    a_fraction_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.distance_valid)
        |-> (o_result.distance_fraction <= drt_pkg::FRAC_ONE))
        else $error("distance fraction above one");

endmodule

// ===== rtl/drt_store.sv =====
// Table store: one write port, one read port, registered read data.
// Depends on drt_pkg for the word layout.
module drt_store #(
    parameter int  TABLE_DEPTH = drt_pkg::TABLE_DEPTH_DEF,
    localparam int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  drt_pkg::t_word      i_wdata,
    input  logic                i_re,
    input  logic [ADDR_W-1:0]   i_raddr,
    output drt_pkg::t_word      o_rdata
);

    drt_pkg::t_word r_mem [TABLE_DEPTH];
    drt_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/drt_div.sv =====
// Restoring divider, one quotient bit per cycle: floor(num * 2^FRAC_BITS / den).
// Needs num <= den and den > 0. Depends on drt_pkg for widths.
module drt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [drt_pkg::SUM_W-1:0]   i_num,
    input  logic [drt_pkg::SUM_W-1:0]   i_den,
    output logic                        o_done,
    output logic [drt_pkg::FRAC_W-1:0]  o_quot
);

    localparam int STEP_W = $clog2(drt_pkg::FRAC_BITS + 1);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic                         r_first, n_first;
    logic [STEP_W-1:0]            r_step, n_step;
    logic [drt_pkg::SUM_W:0]      r_rem, n_rem;
    logic [drt_pkg::SUM_W-1:0]    r_den, n_den;
    logic [drt_pkg::FRAC_W-1:0]   r_q, n_q;
    logic [drt_pkg::SUM_W:0]      w_trial;
    logic                         w_fit;

    // first step compares the numerator itself (integer bit), later ones shift
    assign w_trial = r_first ? r_rem : {r_rem[drt_pkg::SUM_W-1:0], 1'b0};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_first = r_first;
        n_step  = r_step;
        n_rem   = r_rem;
        n_den   = r_den;
        n_q     = r_q;
        if (i_start) begin
            n_busy  = 1'b1;
            n_first = 1'b1;
            n_step  = '0;
            n_rem   = {1'b0, i_num};
            n_den   = i_den;
            n_q     = '0;
        end else if (r_busy) begin
            n_first = 1'b0;
            n_rem   = w_fit ? (w_trial - {1'b0, r_den}) : w_trial;
            n_q     = {r_q[drt_pkg::FRAC_W-2:0], w_fit};
            n_step  = r_step + STEP_W'(1);
            if (r_step == STEP_W'(drt_pkg::FRAC_BITS)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_first <= n_first;
        r_step  <= n_step;
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_q     <= n_q;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/drt_seq.sv =====
// Sequencer: loads, lookups and the build passes over the table store.
// Depends on drt_pkg, drt_in_if, drt_store and drt_div.
module drt_seq #(
    parameter int TABLE_DEPTH = drt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    drt_in_if.sink                i_item,
    input  drt_pkg::t_cfg         i_cfg,
    input  logic                  i_pend_take,
    output drt_pkg::t_result      o_pend,
    output logic                  o_pend_valid,
    output drt_pkg::t_seq_status  o_status
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_LOOK   = 9'b000000010,
        S_SUM    = 9'b000000100,
        S_SUMEND = 9'b000001000,
        S_CHECK  = 9'b000010000,
        S_DSTART = 9'b000100000,
        S_DWAIT  = 9'b001000000,
        S_CLRLO  = 9'b010000000,
        S_CLRHI  = 9'b100000000
    } t_state;

    t_state                     r_state, n_state;
    logic                       r_table_ready, n_table_ready;
    logic                       r_acc_en, n_acc_en;
    logic                       r_pend_valid, n_pend_valid;
    drt_pkg::t_result           r_pend, n_pend;
    logic                       r_look_ok, n_look_ok;
    logic [ADDR_W-1:0]          r_k, n_k;
    logic [ADDR_W-1:0]          r_gs, n_gs;
    logic [ADDR_W-1:0]          r_ge, n_ge;
    logic [CNT_W-1:0]           r_idx, n_idx;
    logic [drt_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [drt_pkg::SUM_W-1:0]  r_tail, n_tail;

    logic                       w_we, w_re;
    logic [ADDR_W-1:0]          w_waddr, w_raddr;
    drt_pkg::t_word             w_wdata, w_rd;
    logic                       w_div_start, w_div_done;
    logic [drt_pkg::FRAC_W-1:0] w_quot;

    logic                       w_accept;
    logic [CNT_W-1:0]           w_n;
    logic [31:0]                w_n32, w_gs32, w_ge32, w_idx32, w_tdc32;
    logic                       w_gate_err, w_empty;

    drt_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    drt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_tail),
        .i_den   (r_sum),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign i_item.ready = (r_state == S_IDLE) && (!r_pend_valid || i_pend_take);
    assign w_accept     = i_item.valid && i_item.ready;

    // entry count saturates at the store depth; gate end clamps to the last entry
    always_comb begin
        if (32'(i_cfg.entry_count) > 32'(TABLE_DEPTH)) begin
            w_n = CNT_W'(TABLE_DEPTH);
        end else begin
            w_n = CNT_W'(i_cfg.entry_count);
        end
        w_n32   = 32'(w_n);
        w_gs32  = 32'(i_cfg.gate_start);
        w_ge32  = (32'(i_cfg.gate_end) < w_n32) ? 32'(i_cfg.gate_end) : (w_n32 - 32'd1);
        w_empty = (w_n32 == 32'd0) || (w_ge32 <= w_gs32);
        w_gate_err = (i_cfg.gate_start >= i_cfg.gate_end);
        w_idx32 = 32'(i_item.bin_index);
        w_tdc32 = 32'(i_item.tdc_value);
    end

    always_comb begin
        n_state       = r_state;
        n_table_ready = r_table_ready;
        n_acc_en      = 1'b0;
        n_pend_valid  = r_pend_valid;
        n_pend        = r_pend;
        n_look_ok     = r_look_ok;
        n_k           = r_k;
        n_gs          = r_gs;
        n_ge          = r_ge;
        n_idx         = r_idx;
        n_sum         = r_acc_en ? (r_sum + drt_pkg::SUM_W'(w_rd.value)) : r_sum;
        n_tail        = r_tail;
        w_we          = 1'b0;
        w_waddr       = '0;
        w_wdata       = '0;
        w_re          = 1'b0;
        w_raddr       = '0;
        w_div_start   = 1'b0;

        if (i_pend_take) begin
            n_pend_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_item.mode)
                        drt_pkg::MODE_LOAD: begin
                            n_table_ready = 1'b0;
                            if (w_idx32 < 32'(TABLE_DEPTH)) begin
                                w_we    = 1'b1;
                                w_waddr = w_idx32[ADDR_W-1:0];
                                w_wdata = '{present: 1'b0,
                                            value: drt_pkg::VAL_W'(i_item.bin_count)};
                            end
                        end
                        drt_pkg::MODE_BUILD: begin
                            if (w_gate_err || w_empty) begin
                                n_table_ready = 1'b0;
                                n_pend_valid  = 1'b1;
                                n_pend        = '{kind: drt_pkg::KIND_STATUS,
                                                  status: w_gate_err ? drt_pkg::ST_GATE_ERR
                                                                     : drt_pkg::ST_ZERO_SUM,
                                                  fraction: '0, dvalid: 1'b0};
                            end else begin
                                n_gs    = w_gs32[ADDR_W-1:0];
                                n_ge    = w_ge32[ADDR_W-1:0];
                                n_k     = w_gs32[ADDR_W-1:0];
                                n_sum   = '0;
                                n_state = S_SUM;
                            end
                        end
                        drt_pkg::MODE_LOOKUP: begin
                            w_re      = 1'b1;
                            w_raddr   = w_tdc32[ADDR_W-1:0];
                            n_look_ok = r_table_ready && (w_tdc32 < w_n32);
                            n_state   = S_LOOK;
                        end
                        default: ;
                    endcase
                end
            end
            S_LOOK: begin
                n_pend_valid = 1'b1;
                n_pend       = '{kind: drt_pkg::KIND_LOOKUP, status: drt_pkg::ST_OK,
                                 fraction: (r_look_ok && w_rd.present)
                                           ? w_rd.value[drt_pkg::FRAC_W-1:0] : '0,
                                 dvalid: r_look_ok && w_rd.present};
                n_state      = S_IDLE;
            end
            // gated sum: one read a cycle, each accumulated from the registered read data
            S_SUM: begin
                w_re     = 1'b1;
                w_raddr  = r_k;
                n_acc_en = 1'b1;
                if (r_k == (r_ge - ADDR_W'(1))) begin
                    n_state = S_SUMEND;
                end else begin
                    n_k = r_k + ADDR_W'(1);
                end
            end
            S_SUMEND: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_sum == '0) begin
                    n_table_ready = 1'b0;
                    n_pend_valid  = 1'b1;
                    n_pend        = '{kind: drt_pkg::KIND_STATUS,
                                      status: drt_pkg::ST_ZERO_SUM,
                                      fraction: '0, dvalid: 1'b0};
                    n_state       = S_IDLE;
                end else begin
                    n_k     = r_ge;
                    n_tail  = '0;
                    n_state = S_DSTART;
                end
            end
            // entry k gets tail/sum; the count below it is fetched before it is overwritten
            S_DSTART: begin
                w_div_start = 1'b1;
                if (r_k != r_gs) begin
                    w_re    = 1'b1;
                    w_raddr = r_k - ADDR_W'(1);
                end
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (w_div_done) begin
                    w_we    = 1'b1;
                    w_waddr = r_k;
                    w_wdata = '{present: 1'b1, value: drt_pkg::VAL_W'(w_quot)};
                    if (r_k == r_gs) begin
                        n_idx   = '0;
                        n_state = S_CLRLO;
                    end else begin
                        n_tail  = r_tail + drt_pkg::SUM_W'(w_rd.value);
                        n_k     = r_k - ADDR_W'(1);
                        n_state = S_DSTART;
                    end
                end
            end
            S_CLRLO: begin
                if (r_idx < CNT_W'(r_gs)) begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[ADDR_W-1:0];
                    n_idx   = r_idx + CNT_W'(1);
                end else begin
                    n_idx   = CNT_W'(r_ge) + CNT_W'(1);
                    n_state = S_CLRHI;
                end
            end
            S_CLRHI: begin
                if (r_idx < w_n) begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[ADDR_W-1:0];
                    n_idx   = r_idx + CNT_W'(1);
                end else begin
                    n_table_ready = 1'b1;
                    n_pend_valid  = 1'b1;
                    n_pend        = '{kind: drt_pkg::KIND_STATUS, status: drt_pkg::ST_OK,
                                      fraction: '0, dvalid: 1'b0};
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_table_ready <= 1'b0;
            r_acc_en      <= 1'b0;
            r_pend_valid  <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_table_ready <= n_table_ready;
            r_acc_en      <= n_acc_en;
            r_pend_valid  <= n_pend_valid;
        end
        r_pend    <= n_pend;
        r_look_ok <= n_look_ok;
        r_k       <= n_k;
        r_gs      <= n_gs;
        r_ge      <= n_ge;
        r_idx     <= n_idx;
        r_sum     <= n_sum;
        r_tail    <= n_tail;
    end

    assign o_pend       = r_pend;
    assign o_pend_valid = r_pend_valid;
    assign o_status     = '{busy: (r_state != S_IDLE), table_ready: r_table_ready};

endmodule

// ===== dv/drift_time_table_builder_tb.sv =====
// Self-checking bench for drift_time_table_builder: directed table, then random load/build/lookup.
// Depends on drt_pkg, the DUT top and the drt_in_if, drt_out_if and drt_cfg_if channel interfaces.
// An in-bench copy of the table store predicts build statuses and lookup replies, bar fixed directed ones.
module drift_time_table_builder_tb;
    import drt_pkg::*;

    localparam int      DEPTH           = TABLE_DEPTH_DEF;
    localparam int      CLK_PERIOD      = 12;
    localparam int      RESET_CYCLES    = 7;
    localparam int      SETTLE_CYCLES   = 6;
    localparam int      DRAIN_CYCLES    = 40;
    localparam int      RANDOM_ITEMS    = 400;
    localparam longint  WATCHDOG_CYCLES = 2_000_000;

    // mode 3 carries no operation; the block drops it
    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

    typedef struct {
        bit                     is_cfg;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
        logic [MODE_W-1:0]      mode;
        logic [INDEX_W-1:0]     idx;
        logic [COUNT_BITS-1:0]  cnt;
        logic [TDC_W-1:0]       tdc;
        bit                     fixed_exp;
        t_result                res;
    } t_step;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    drt_in_if  item_ch();
    drt_out_if result_ch();
    drt_cfg_if cfg_ch();

    drift_time_table_builder u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // bench copy of the table and its registers
    logic [VAL_W-1:0]   bin_val     [DEPTH];
    bit                 bin_present [DEPTH];
    bit                 tbl_ready = 1'b0;
    logic [GATE_W-1:0]  cur_gs    = '0;
    logic [GATE_W-1:0]  cur_ge    = '0;
    logic [ENTRY_W-1:0] cur_ec    = '0;

    t_result replies_due[$];
    t_step   directed[$];
    int      n_errors     = 0;
    int      items_sent   = 0;
    bit      calm_sender  = 1'b0;

    function automatic logic [FRAC_W-1:0] distance_fraction_of(longint unsigned num,
                                                             longint unsigned den);
        return FRAC_W'((num << FRAC_BITS) / den);
    endfunction

    function automatic logic [STATUS_W-1:0] rebuild_distance_table();
        int n;
        int gs;
        int gend;
        longint unsigned total;
        longint unsigned tail;
        longint unsigned cnt;
        n  = (cur_ec > DEPTH) ? DEPTH : int'(cur_ec);
        gs = int'(cur_gs);
        if (cur_gs >= cur_ge) begin
            tbl_ready = 1'b0;
            return ST_GATE_ERR;
        end
        // gate end clamps to the last entry, possibly below the start
        gend  = (int'(cur_ge) > n - 1) ? n - 1 : int'(cur_ge);
        total = 0;
        for (int i = gs; i < gend; i++) total += bin_val[i];
        if (total == 0) begin
            tbl_ready = 1'b0;
            return ST_ZERO_SUM;
        end
        tail = 0;
        for (int i = gend - 1; i >= gs; i--) begin
            cnt = bin_val[i];
            bin_val[i + 1]     = VAL_W'(distance_fraction_of(tail, total));
            bin_present[i + 1] = 1'b1;
            tail += cnt;
        end
        bin_val[gs]     = VAL_W'(distance_fraction_of(tail, total));
        bin_present[gs] = 1'b1;
        for (int i = 0; i < gs; i++) begin
            bin_val[i]     = '0;
            bin_present[i] = 1'b0;
        end
        for (int i = gend + 1; i < n; i++) begin
            bin_val[i]     = '0;
            bin_present[i] = 1'b0;
        end
        tbl_ready = 1'b1;
        return ST_OK;
    endfunction

    // Updates the bench table for one item; returns 1 when the item yields a reply.
    function automatic bit apply_table_item(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                                            logic [COUNT_BITS-1:0] cnt,
                                            logic [TDC_W-1:0] tdc, output t_result res);
        res = '0;
        case (mode)
            MODE_LOAD: begin
                bin_val[idx]     = VAL_W'(cnt);
                bin_present[idx] = 1'b0;
                tbl_ready        = 1'b0;
                return 1'b0;
            end
            MODE_BUILD: begin
                res.kind   = KIND_STATUS;
                res.status = rebuild_distance_table();
                return 1'b1;
            end
            MODE_LOOKUP: begin
                res.kind   = KIND_LOOKUP;
                res.status = ST_OK;
                if (tbl_ready && tdc < cur_ec && tdc < DEPTH && bin_present[tdc]) begin
                    res.fraction = bin_val[tdc][FRAC_W-1:0];
                    res.dvalid   = 1'b1;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GATE_START:  cur_gs = data[GATE_W-1:0];
            CFG_GATE_END:    cur_ge = data[GATE_W-1:0];
            CFG_ENTRY_COUNT: cur_ec = data[ENTRY_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            n_errors++;
        end
    endfunction

    // reply checker
    always @(posedge i_clk) begin : reply_check
        t_result want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (replies_due.size() == 0) begin
                $display({"%0t: unexpected reply, expected none, ",
                          "actual kind %0d status %0d frac %0d dvalid %0d"},
                         $time, result_ch.result_kind, result_ch.build_status,
                         result_ch.distance_fraction, result_ch.distance_valid);
                n_errors++;
            end else begin
                want = replies_due.pop_front();
                compare_field("result_kind", 32'(want.kind), 32'(result_ch.result_kind));
                compare_field("build_status", 32'(want.status), 32'(result_ch.build_status));
                compare_field("distance_fraction", 32'(want.fraction),
                              32'(result_ch.distance_fraction));
                compare_field("distance_valid", 32'(want.dvalid),
                              32'(result_ch.distance_valid));
            end
        end
    end

    // receiver back-pressure: short and long stalls, with the odd calm stretch
    initial begin : reply_sink
        int hold;
        int r;
        hold = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8) begin
                    result_ch.ready <= 1'b1;
                    hold = $urandom_range(50, 200);
                end else if (r < 60) begin
                    result_ch.ready <= 1'b1;
                    hold = $urandom_range(0, 8);
                end else if (r < 90) begin
                    result_ch.ready <= 1'b0;
                    hold = $urandom_range(0, 3);
                end else begin
                    result_ch.ready <= 1'b0;
                    hold = $urandom_range(5, 30);
                end
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (calm_sender) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [COUNT_BITS-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 25) return '1;
        if (r < 55) return COUNT_BITS'($urandom_range(1, 255));
        return COUNT_BITS'($urandom);
    endfunction

    function automatic logic [TDC_W-1:0] pick_tdc(int n);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return TDC_W'($urandom_range(0, n - 1));
        if (r < 85) return TDC_W'($urandom_range(n, n + 3));
        return TDC_W'($urandom);
    endfunction

    // Lowers the item valid and holds off until every awaited reply is in.
    task automatic wait_replies_drained();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (replies_due.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_replies_drained();
        // loads give no reply, so allow the last one to retire
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_reg(idx, data);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_item(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                             logic [COUNT_BITS-1:0] cnt, logic [TDC_W-1:0] tdc,
                             bit fixed_exp = 1'b0, t_result fixed_res = '0);
        int gap;
        t_result res;
        gap = sender_gap();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.mode      <= mode;
        item_ch.bin_index <= idx;
        item_ch.bin_count <= cnt;
        item_ch.tdc_value <= tdc;
        do @(posedge i_clk); while (!item_ch.ready);
        if (apply_table_item(mode, idx, cnt, tdc, res))
            replies_due.push_back(fixed_exp ? fixed_res : res);
        if (mode != MODE_IGNORED) items_sent++;
    endtask

    function automatic t_step reg_step(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_step s;
        s          = '{default: '0};
        s.is_cfg   = 1'b1;
        s.reg_idx  = idx;
        s.reg_data = data;
        return s;
    endfunction

    function automatic t_step item_step(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                                        logic [COUNT_BITS-1:0] cnt, logic [TDC_W-1:0] tdc,
                                        bit fixed_exp = 1'b0, t_result res = '0);
        t_step s;
        s           = '{default: '0};
        s.mode      = mode;
        s.idx       = idx;
        s.cnt       = cnt;
        s.tdc       = tdc;
        s.fixed_exp = fixed_exp;
        s.res       = res;
        return s;
    endfunction

    function automatic t_result status_reply(logic [STATUS_W-1:0] st);
        t_result r;
        r        = '0;
        r.kind   = KIND_STATUS;
        r.status = st;
        return r;
    endfunction

    function automatic t_result lookup_reply(logic [FRAC_W-1:0] frac, logic dv);
        t_result r;
        r          = '0;
        r.kind     = KIND_LOOKUP;
        r.status   = ST_OK;
        r.fraction = frac;
        r.dvalid   = dv;
        return r;
    endfunction

    // Well-formed pass: set a gate, load the gated bins unless skipped, build, then look up.
    task automatic run_table_phase();
        int n;
        int gs;
        int ge;
        int gend;
        int ec_w;
        int r;
        bit zero_fill;
        bit skip_load;
        r = $urandom_range(0, 99);
        if (r < 85)      n = $urandom_range(2, 24);
        else if (r < 96) n = $urandom_range(25, 160);
        else             n = $urandom_range(3900, DEPTH);
        gs   = (n > 48) ? $urandom_range(n - 48, n - 2) : $urandom_range(0, n - 2);
        ge   = ($urandom_range(0, 4) == 0) ? $urandom_range(n - 1, 4095)
                                           : $urandom_range(gs + 1, n - 1);
        gend = (ge > n - 1) ? n - 1 : ge;
        ec_w = (n == DEPTH && $urandom_range(0, 1) == 1) ? $urandom_range(DEPTH + 1, 8191) : n;
        write_reg(CFG_GATE_START, CFG_DATA_W'(gs));
        write_reg(CFG_GATE_END, CFG_DATA_W'(ge));
        write_reg(CFG_ENTRY_COUNT, CFG_DATA_W'(ec_w));
        zero_fill = ($urandom_range(0, 9) == 0);
        // now and then rebuild straight from whatever the store holds
        skip_load = ($urandom_range(0, 6) == 0);
        if (!skip_load) begin
            for (int k = gs; k < gend; k++)
                send_item(MODE_LOAD, INDEX_W'(k), zero_fill ? '0 : pick_count(),
                          TDC_W'($urandom));
        end
        if ($urandom_range(0, 2) == 0)
            send_item(MODE_LOAD, INDEX_W'($urandom_range(0, n - 1)), pick_count(),
                      TDC_W'($urandom));
        send_item(MODE_BUILD, INDEX_W'($urandom), COUNT_BITS'($urandom), TDC_W'($urandom));
        repeat ($urandom_range(4, 20))
            send_item(MODE_LOOKUP, INDEX_W'($urandom), COUNT_BITS'($urandom), pick_tdc(n));
        if ($urandom_range(0, 5) == 0) begin
            send_item(MODE_BUILD, INDEX_W'($urandom), COUNT_BITS'($urandom), TDC_W'($urandom));
            repeat ($urandom_range(2, 6))
                send_item(MODE_LOOKUP, INDEX_W'($urandom), COUNT_BITS'($urandom), pick_tdc(n));
        end
    endtask

    // Noise: at times arbitrary registers, and a random mix of every mode.
    task automatic run_noise_phase();
        int gs;
        int ge;
        int ec;
        int n;
        int gend;
        logic [MODE_W-1:0] mode;
        gs   = $urandom_range(0, 4095);
        ge   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, gs) : $urandom_range(0, 4095);
        ec   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, DEPTH);
        n    = (ec > DEPTH) ? DEPTH : ec;
        gend = (ge > n - 1) ? n - 1 : ge;
        // keep the divider pass short
        if (gs < ge && gend - gs > 300) ge = gs + $urandom_range(1, 300);
        if ($urandom_range(0, 1) == 1) begin
            // bit 12 of a gate write lies above the register and is dropped
            write_reg(CFG_GATE_START, {1'($urandom), GATE_W'(gs)});
            write_reg(CFG_GATE_END, {1'($urandom), GATE_W'(ge)});
            write_reg(CFG_ENTRY_COUNT, CFG_DATA_W'(ec));
        end
        repeat ($urandom_range(5, 20)) begin
            mode = MODE_W'($urandom_range(0, 3));
            send_item(mode, INDEX_W'($urandom), pick_count(),
                      ($urandom_range(0, 1) == 1) ? TDC_W'($urandom)
                                                  : TDC_W'($urandom_range(0, 4200)));
        end
    endtask

    initial begin : stimulus
        int random_target;
        item_ch.valid     = 1'b0;
        item_ch.mode      = MODE_LOAD;
        item_ch.bin_index = '0;
        item_ch.bin_count = '0;
        item_ch.tdc_value = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_GATE_START;
        cfg_ch.data       = '0;
        foreach (bin_val[i]) begin
            bin_val[i]     = '0;
            bin_present[i] = 1'b0;
        end

        // table not built yet; gate registers still both zero
        directed.push_back(item_step(MODE_LOOKUP, '0, '0, 16'd0, 1'b1, lookup_reply('0, 1'b0)));
        directed.push_back(item_step(MODE_BUILD, '0, '0, '0, 1'b1, status_reply(ST_GATE_ERR)));
        // empty clamped gate while the entry count is zero
        directed.push_back(reg_step(CFG_GATE_START, 13'd4090));
        directed.push_back(reg_step(CFG_GATE_END, 13'd4095));
        directed.push_back(item_step(MODE_BUILD, '0, '0, '0, 1'b1, status_reply(ST_ZERO_SUM)));
        // top of the store; this build also marks every lower bin absent
        directed.push_back(reg_step(CFG_ENTRY_COUNT, 13'd4096));
        directed.push_back(item_step(MODE_LOAD, 12'd4090, 24'hFF_FFFF, '0));
        directed.push_back(item_step(MODE_LOAD, 12'd4091, 24'h00_0000, '1));
        directed.push_back(item_step(MODE_LOAD, 12'd4092, 24'h00_0001, '0));
        directed.push_back(item_step(MODE_LOAD, 12'd4093, 24'hFF_FFFF, '1));
        directed.push_back(item_step(MODE_LOAD, 12'd4094, 24'h80_0000, '0));
        directed.push_back(item_step(MODE_BUILD, '1, '1, '1, 1'b1, status_reply(ST_OK)));
        directed.push_back(item_step(MODE_LOOKUP, '0, '0, 16'd4090, 1'b1,
                                     lookup_reply(FRAC_ONE, 1'b1)));
        directed.push_back(item_step(MODE_LOOKUP, '0, '0, 16'd4095, 1'b1,
                                     lookup_reply('0, 1'b1)));
        directed.push_back(item_step(MODE_LOOKUP, '0, '0, 16'd4089, 1'b1,
                                     lookup_reply('0, 1'b0)));
        directed.push_back(item_step(MODE_LOOKUP, '0, '0, 16'hFFFF, 1'b1,
                                     lookup_reply('0, 1'b0)));
        directed.push_back(item_step(MODE_LOOKUP, '0, '0, 16'd4092));
        directed.push_back(item_step(MODE_IGNORED, '1, '1, '1));
        // entry count beyond the store depth
        directed.push_back(reg_step(CFG_ENTRY_COUNT, 13'd8191));
        directed.push_back(item_step(MODE_LOOKUP, '0, '0, 16'd4094));
        directed.push_back(item_step(MODE_LOOKUP, '0, '0, 16'd5000, 1'b1,
                                     lookup_reply('0, 1'b0)));
        // rebuild reads the stored fractions back as counts
        directed.push_back(item_step(MODE_BUILD, '0, '0, '0));
        directed.push_back(item_step(MODE_LOOKUP, '0, '0, 16'd4093));
        directed.push_back(item_step(MODE_LOAD, 12'd4095, 24'd5, '0));
        directed.push_back(item_step(MODE_LOOKUP, '0, '0, 16'd4090, 1'b1,
                                     lookup_reply('0, 1'b0)));
        directed.push_back(reg_step(CFG_GATE_START, 13'd10));
        directed.push_back(reg_step(CFG_GATE_END, 13'd10));
        directed.push_back(item_step(MODE_BUILD, '0, '0, '0, 1'b1, status_reply(ST_GATE_ERR)));
        // gated bins all zero
        directed.push_back(reg_step(CFG_GATE_START, 13'd5));
        directed.push_back(reg_step(CFG_GATE_END, 13'd9));
        directed.push_back(reg_step(CFG_ENTRY_COUNT, 13'd7));
        directed.push_back(item_step(MODE_LOAD, 12'd0, 24'hFF_FFFF, '0));
        directed.push_back(item_step(MODE_LOAD, 12'd5, 24'd0, '0));
        directed.push_back(item_step(MODE_BUILD, '0, '0, '0, 1'b1, status_reply(ST_ZERO_SUM)));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].is_cfg)
                write_reg(directed[i].reg_idx, directed[i].reg_data);
            else
                send_item(directed[i].mode, directed[i].idx, directed[i].cnt, directed[i].tdc,
                          directed[i].fixed_exp, directed[i].res);
        end

        random_target = items_sent + RANDOM_ITEMS;
        while (items_sent < random_target) begin
            calm_sender = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 75)
                run_table_phase();
            else
                run_noise_phase();
            if ($urandom_range(0, 3) == 0) wait_replies_drained();
        end

        wait_replies_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("[drift_time_table_builder] OK");
        else
            $display("[drift_time_table_builder] ERROR");
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * WATCHDOG_CYCLES);
        $display("%0t: timeout with %0d replies outstanding", $time, replies_due.size());
        $display("[drift_time_table_builder] ERROR");
        $finish;
    end

endmodule
